>>> src/gcd_pkg.sv
// Package for the greedy convolutional decoder: configuration struct,
// register indexes and fixed-point constants.
// No dependencies.
package gcd_pkg;

	localparam int SAMPLE_PORTS = 4;    // sample ports on the input channel
	localparam int GEN_BITS     = 8;    // width of a generator tap mask
	localparam int TAP_LIMIT    = 16;   // largest supported MAX_TAPS
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 8;
	localparam int FIX_ONE      = 32;   // 1.0
	localparam int FIX_HALF     = 16;   // 0.5

	localparam logic [CFG_IDX_W-1:0] REG_CONSTRAINT_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_OUTPUTS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_ROW_0         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_ROW_1         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_ROW_2         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GEN_ROW_3         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DECISION_MODE     = 3'd6;

	localparam logic MODE_HARD = 1'b0;
	localparam logic MODE_SOFT = 1'b1;

	typedef struct packed {
		logic [3:0]                                  constraint_length;
		logic [2:0]                                  code_outputs;
		logic [SAMPLE_PORTS-1:0][GEN_BITS-1:0]       gen_row;
		logic                                        decision_mode;
	} cfg_t;

endpackage

>>> src/gcd_lane.sv
// One branch-metric lane: cost of one received sample against expected
// code bit 0 and 1, registered. Depends on gcd_pkg.
module gcd_lane
	import gcd_pkg::*;
#(
	parameter int SAMPLE_BITS = 8,
	parameter int COST_W      = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          mode,
	input  logic                          active,
	output logic [COST_W-1:0]             cost0_s1,
	output logic [COST_W-1:0]             cost1_s1
);

	localparam int DIFF_BITS = COST_W / 2;
	localparam logic signed [DIFF_BITS-1:0] ONE_D  = DIFF_BITS'(FIX_ONE);
	localparam logic signed [DIFF_BITS-1:0] HALF_D = DIFF_BITS'(FIX_HALF);

	logic signed [DIFF_BITS-1:0] sx;
	logic signed [DIFF_BITS-1:0] diff0;
	logic signed [DIFF_BITS-1:0] diff1;
	logic signed [COST_W-1:0]    sq0;
	logic signed [COST_W-1:0]    sq1;
	logic                        hard_bit;
	logic [COST_W-1:0]           cost0;
	logic [COST_W-1:0]           cost1;

	assign sx       = DIFF_BITS'(sample);
	assign diff0    = sx + ONE_D;   // expected -1.0
	assign diff1    = sx - ONE_D;   // expected +1.0
	assign sq0      = diff0 * diff0;
	assign sq1      = diff1 * diff1;
	assign hard_bit = !(sx < HALF_D);

	always_comb begin
		cost0 = '0;
		cost1 = '0;
		if (active) begin
			if (mode == MODE_SOFT) begin
				cost0 = $unsigned(sq0);
				cost1 = $unsigned(sq1);
			end else begin
				cost0 = COST_W'(hard_bit);
				cost1 = COST_W'(!hard_bit);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cost0_s1 <= cost0;
			cost1_s1 <= cost1;
		end
	end

endmodule

>>> src/gcd_merge.sv
// Merge stage: forms expected code bits from history and generator masks,
// sums lane costs for both trial bits, decides and updates history.
// Depends on gcd_pkg.
module gcd_merge
	import gcd_pkg::*;
#(
	parameter int MAX_TAPS  = 8,
	parameter int NUM_LANES = 4,
	parameter int COST_W    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cfg_t                               cfg,
	input  logic [NUM_LANES-1:0][COST_W-1:0]   cost0_s1,
	input  logic [NUM_LANES-1:0][COST_W-1:0]   cost1_s1,
	input  logic                               last_s1,
	input  logic                               adv,
	output logic                               bit_dec
);

	localparam int SUM_W = COST_W + $clog2(NUM_LANES + 1);

	logic [MAX_TAPS-2:0] hist_q;
	logic [MAX_TAPS-1:0] taps_mask;
	logic [MAX_TAPS-1:0] reg0;
	logic [SUM_W-1:0]    d0;
	logic [SUM_W-1:0]    d1;

	always_comb begin
		for (int b = 0; b < MAX_TAPS; b++) begin
			taps_mask[b] = (5'(b) < {1'b0, cfg.constraint_length});
		end
	end

	assign reg0 = {hist_q, 1'b0};

	always_comb begin
		logic [TAP_LIMIT-1:0] g_wide;
		logic [MAX_TAPS-1:0]  m;
		logic                 e0;
		logic                 e1;
		d0 = '0;
		d1 = '0;
		for (int j = 0; j < NUM_LANES; j++) begin
			g_wide = TAP_LIMIT'(cfg.gen_row[j]);
			m      = g_wide[MAX_TAPS-1:0] & taps_mask;
			e0     = ^(reg0 & m);
			e1     = e0 ^ m[0];     // trial bit sits on tap 0
			d0 = d0 + SUM_W'(e0 ? cost1_s1[j] : cost0_s1[j]);
			d1 = d1 + SUM_W'(e1 ? cost1_s1[j] : cost0_s1[j]);
		end
	end

	// ties go to 0
	assign bit_dec = (d1 < d0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				hist_q <= '0;
			end else begin
				hist_q <= reg0[MAX_TAPS-2:0] | (MAX_TAPS-1)'(bit_dec);
			end
		end
	end

endmodule

>>> src/greedy_convolutional_decoder_core.sv
// Greedy convolutional decoder, single survivor path.
// Pipeline: an input transfer loads the lane register; the merge result then loads the
// output register, which drives out_valid, once that register is empty or being drained.
// Throughput: one codeword per cycle while out_stall is low; the decision-to-history
// loop closes inside the merge stage, one lane cost pair per sample feeds it.
// Reset: configuration returns to K=3, two outputs, generators 7 and 5, hard
// decisions; history and pipeline valids clear.
module greedy_convolutional_decoder_core
	import gcd_pkg::*;
#(
	parameter int MAX_TAPS    = 8,
	parameter int MAX_OUTPUTS = 4,
	parameter int SAMPLE_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_0,
	input  logic signed [SAMPLE_BITS-1:0] sample_1,
	input  logic signed [SAMPLE_BITS-1:0] sample_2,
	input  logic signed [SAMPLE_BITS-1:0] sample_3,
	input  logic                          last_in_frame,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          decoded_bit,
	output logic                          frame_end
);

	localparam int NUM_LANES = (MAX_OUTPUTS < SAMPLE_PORTS) ? MAX_OUTPUTS : SAMPLE_PORTS;
	localparam int DIFF_BITS = ((SAMPLE_BITS > 6) ? SAMPLE_BITS : 7) + 1;
	localparam int COST_W    = 2 * DIFF_BITS;

	cfg_t cfg_q;
	logic signed [SAMPLE_BITS-1:0] smp [SAMPLE_PORTS];
	logic [NUM_LANES-1:0][COST_W-1:0] cost0_s1;
	logic [NUM_LANES-1:0][COST_W-1:0] cost1_s1;
	logic v_s1;
	logic last_s1;
	logic out_valid_q;
	logic bit_dec;
	logic ready2;
	logic adv;
	logic in_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.constraint_length <= 4'd3;
			cfg_q.code_outputs      <= 3'd2;
			cfg_q.gen_row[0]        <= 8'd7;
			cfg_q.gen_row[1]        <= 8'd5;
			cfg_q.gen_row[2]        <= 8'd0;
			cfg_q.gen_row[3]        <= 8'd0;
			cfg_q.decision_mode     <= MODE_HARD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONSTRAINT_LENGTH: cfg_q.constraint_length <= cfg_data[3:0];
				REG_CODE_OUTPUTS:      cfg_q.code_outputs      <= cfg_data[2:0];
				REG_GEN_ROW_0:         cfg_q.gen_row[0]        <= cfg_data;
				REG_GEN_ROW_1:         cfg_q.gen_row[1]        <= cfg_data;
				REG_GEN_ROW_2:         cfg_q.gen_row[2]        <= cfg_data;
				REG_GEN_ROW_3:         cfg_q.gen_row[3]        <= cfg_data;
				REG_DECISION_MODE:     cfg_q.decision_mode     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign smp[0] = sample_0;
	assign smp[1] = sample_1;
	assign smp[2] = sample_2;
	assign smp[3] = sample_3;

	// output register takes a transfer when empty or being drained
	assign ready2   = !out_valid_q || !out_stall;
	assign adv      = v_s1 && ready2;
	assign in_stall = v_s1 && !ready2;
	assign in_xfer  = in_valid && !in_stall;

	for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
		gcd_lane #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.COST_W      (COST_W)
		) u_lane (
			.clk      (clk),
			.en       (in_xfer),
			.sample   (smp[j]),
			.mode     (cfg_q.decision_mode),
			.active   (cfg_q.code_outputs > 3'(j)),
			.cost0_s1 (cost0_s1[j]),
			.cost1_s1 (cost1_s1[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_xfer) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			last_s1 <= last_in_frame;
		end
	end

	gcd_merge #(
		.MAX_TAPS  (MAX_TAPS),
		.NUM_LANES (NUM_LANES),
		.COST_W    (COST_W)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cost0_s1 (cost0_s1),
		.cost1_s1 (cost1_s1),
		.last_s1  (last_s1),
		.adv      (adv),
		.bit_dec  (bit_dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready2) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			decoded_bit <= bit_dec;
			frame_end   <= last_s1;
		end
	end

	assign out_valid = out_valid_q;

	// input only blocked when both stages hold a result
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && out_valid_q))
		else $error("input stalled with a free stage");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v_s1))
		else $error("result appeared without a lane-stage item");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid_q && out_stall) |=> v_s1)
		else $error("lane-stage item lost while output blocked");

endmodule
